// ----- rtl/core/rped_pkg.sv -----
// Package for the Euler-angle point rotator: CORDIC arctangent table,
// Q2.30 rounded product helper and shared widths.
// Depends on nothing; used by the trig unit and the top level.
package rped_pkg;

   // Width of the Q2.30 trig values and matrix entries, with headroom
   localparam int TrigW = 34;
   // Number of entries in the arctangent table
   localparam int AtanLen = 24;
   // Start vector: reciprocal of the infinite-stage CORDIC gain in Q2.30
   localparam logic signed [TrigW-1:0] CordicStart = 34'sd652032874;

   typedef logic signed [TrigW-1:0] trig_type;

   // atan(2^-i) in units of 2^-32 of a full turn
   function automatic logic signed [32:0] atan_turns(input int i);
      logic signed [32:0] r;
      case (i)
         0:  r = 33'sh020000000;
         1:  r = 33'sh012E4051E;
         2:  r = 33'sh009FB385B;
         3:  r = 33'sh0051111D4;
         4:  r = 33'sh0028B0D43;
         5:  r = 33'sh00145D7E1;
         6:  r = 33'sh000A2F61E;
         7:  r = 33'sh000517C55;
         8:  r = 33'sh00028BE53;
         9:  r = 33'sh000145F2F;
         10: r = 33'sh0000A2F98;
         11: r = 33'sh0000517CC;
         12: r = 33'sh000028BE6;
         13: r = 33'sh0000145F3;
         14: r = 33'sh00000A2FA;
         15: r = 33'sh00000517D;
         16: r = 33'sh0000028BE;
         17: r = 33'sh00000145F;
         18: r = 33'sh000000A30;
         19: r = 33'sh000000518;
         20: r = 33'sh00000028C;
         21: r = 33'sh000000146;
         22: r = 33'sh0000000A3;
         23: r = 33'sh000000051;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q2.30 product, rounded half up
   function automatic trig_type mulq(input trig_type a, input trig_type b);
      logic signed [2*TrigW-1:0] p;
      p = a * b + (2*TrigW)'(64'sd1 <<< 29);
      return trig_type'(p >>> 30);
   endfunction

endpackage

// ----- rtl/core/rped_if.sv -----
// Channel interfaces of the point rotator: request (point and angles) and
// response (rotated point). Valid/ready handshake; no package dependency.
interface rped_req_if #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] px;
   logic signed [COORD_WIDTH-1:0] py;
   logic signed [COORD_WIDTH-1:0] pz;
   logic signed [ANGLE_WIDTH-1:0] roll_angle;
   logic signed [ANGLE_WIDTH-1:0] pitch_angle;
   logic signed [ANGLE_WIDTH-1:0] yaw_angle;

   modport source(output valid, px, py, pz, roll_angle, pitch_angle, yaw_angle,
                  input ready);
   modport sink(input valid, px, py, pz, roll_angle, pitch_angle, yaw_angle,
                output ready);
endinterface

interface rped_rsp_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rx;
   logic signed [COORD_WIDTH-1:0] ry;
   logic signed [COORD_WIDTH-1:0] rz;

   modport source(output valid, rx, ry, rz, input ready);
   modport sink(input valid, rx, ry, rz, output ready);
endinterface

// ----- rtl/core/rped_trig.sv -----
// Pipelined sine/cosine of one binary angle: quadrant fold, TRIG_STAGES
// CORDIC rotations, quadrant restore. Depends on rped_pkg.
module rped_trig #(
   parameter int ANGLE_WIDTH = 16,
   parameter int TRIG_STAGES = 16
) (
   input  logic                          clock,
   input  logic [TRIG_STAGES+1:0]        stage_en,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   output rped_pkg::trig_type            cos_out,
   output rped_pkg::trig_type            sin_out
);
   import rped_pkg::*;

   logic [31:0]        a_turn;
   logic [1:0]         quad_in;
   logic [31:0]        u_in;

   logic signed [32:0] z_ff [0:TRIG_STAGES];
   logic [1:0]         q_ff [0:TRIG_STAGES];
   trig_type           x_ff [1:TRIG_STAGES];
   trig_type           y_ff [1:TRIG_STAGES];
   trig_type           cos_ff, sin_ff;

   // fold to nearest quadrant; residue in 2^-32 turns
   always_comb begin
      a_turn  = {angle, {(32-ANGLE_WIDTH){1'b0}}};
      quad_in = 2'((a_turn + 32'h2000_0000) >> 30);
      u_in    = a_turn - {quad_in, 30'b0};
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         z_ff[0] <= {u_in[31], u_in};
         q_ff[0] <= quad_in;
      end
   end

   // one CORDIC rotation per stage
   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
      trig_type x_prev, y_prev, dx, dy;
      if (i == 0) begin : g_first
         assign x_prev = CordicStart;
         assign y_prev = '0;
      end else begin : g_next
         assign x_prev = x_ff[i];
         assign y_prev = y_ff[i];
      end
      assign dx = y_prev >>> i;
      assign dy = x_prev >>> i;

      always_ff @(posedge clock) begin
         if (stage_en[i+1]) begin
            q_ff[i+1] <= q_ff[i];
            if (!z_ff[i][32]) begin
               x_ff[i+1] <= x_prev - dx;
               y_ff[i+1] <= y_prev + dy;
               z_ff[i+1] <= z_ff[i] - atan_turns(i);
            end else begin
               x_ff[i+1] <= x_prev + dx;
               y_ff[i+1] <= y_prev - dy;
               z_ff[i+1] <= z_ff[i] + atan_turns(i);
            end
         end
      end
   end

   // restore quadrant
   always_ff @(posedge clock) begin
      if (stage_en[TRIG_STAGES+1]) begin
         case (q_ff[TRIG_STAGES])
            2'd0: begin
               cos_ff <= x_ff[TRIG_STAGES];
               sin_ff <= y_ff[TRIG_STAGES];
            end
            2'd1: begin
               cos_ff <= -y_ff[TRIG_STAGES];
               sin_ff <= x_ff[TRIG_STAGES];
            end
            2'd2: begin
               cos_ff <= -x_ff[TRIG_STAGES];
               sin_ff <= -y_ff[TRIG_STAGES];
            end
            default: begin
               cos_ff <= y_ff[TRIG_STAGES];
               sin_ff <= -x_ff[TRIG_STAGES];
            end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule

// ----- rtl/core/rotate_point_euler_3d.sv -----
// Top level of the Z-Y-X Euler point rotator.
// Depends on rped_pkg, rped_if (channels) and rped_trig (sine/cosine unit).
//
// Rotates a Q16.16 point by R = Rz(yaw)*Ry(pitch)*Rx(roll), with binary
// angles (2^(ANGLE_WIDTH-1) is pi). Fully pipelined: one point per cycle
// while the sink is ready, through fold, TRIG_STAGES CORDIC rotations,
// quadrant restore, two product stages, matrix sum, row products, row sums,
// round and saturate. Each stage holds its item while the next is full, so
// bubbles close up; while a result waits the input keeps moving until the
// empty stages have filled.
module rotate_point_euler_3d #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16,
   parameter int TRIG_STAGES = 16
) (
   input logic      clock,
   input logic      reset,
   rped_req_if.sink   req_ch,
   rped_rsp_if.source rsp_ch
);
   import rped_pkg::*;

   localparam int T    = TRIG_STAGES;
   localparam int NS   = T + 8;
   localparam int S_M1 = T + 2;
   localparam int S_M2 = T + 3;
   localparam int S_M3 = T + 4;
   localparam int S_R1 = T + 5;
   localparam int S_R2 = T + 6;
   localparam int S_R3 = T + 7;
   localparam int HW   = COORD_WIDTH - 16 + TrigW;
   localparam int LW   = 17 + TrigW;
   localparam int SAW  = HW + 2;
   localparam int SBW  = LW + 2;
   localparam int VW   = ((SAW > SBW - 16) ? SAW : SBW - 16) + 1;
   localparam logic signed [VW-15:0] LimHi = (VW-14)'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
   localparam logic signed [VW-15:0] LimLo = -LimHi - 1;

   // valid bits and stage enables
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en_s;

   always_comb begin
      en_s[NS-1] = !v_ff[NS-1] || rsp_ch.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en_s[i] = !v_ff[i] || en_s[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en_s[0]) v_ff[0] <= req_ch.valid;
         for (int i = 1; i < NS; i++) begin
            if (en_s[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   assign req_ch.ready = en_s[0];

   // point delay line up to the row products
   logic signed [COORD_WIDTH-1:0] pt_ff [0:S_M3][0:2];

   always_ff @(posedge clock) begin
      if (en_s[0]) begin
         pt_ff[0][0] <= req_ch.px;
         pt_ff[0][1] <= req_ch.py;
         pt_ff[0][2] <= req_ch.pz;
      end
      for (int s = 1; s <= S_M3; s++) begin
         if (en_s[s]) pt_ff[s] <= pt_ff[s-1];
      end
   end

   // sine and cosine of each angle
   trig_type cr, sr, cp, sp, cy, sy;

   rped_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(T)) u_roll (
      .clock(clock), .stage_en(en_s[T+1:0]), .angle(req_ch.roll_angle),
      .cos_out(cr), .sin_out(sr));
   rped_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(T)) u_pitch (
      .clock(clock), .stage_en(en_s[T+1:0]), .angle(req_ch.pitch_angle),
      .cos_out(cp), .sin_out(sp));
   rped_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(T)) u_yaw (
      .clock(clock), .stage_en(en_s[T+1:0]), .angle(req_ch.yaw_angle),
      .cos_out(cy), .sin_out(sy));

   // first products of angle terms
   trig_type srsp_ff, crsp_ff, cpcy_ff, cpsy_ff, crsy_ff, crcy_ff;
   trig_type srsy_ff, srcy_ff, srcp_ff, crcp_ff, nsp_ff, cy_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (en_s[S_M1]) begin
         srsp_ff <= mulq(sr, sp);
         crsp_ff <= mulq(cr, sp);
         cpcy_ff <= mulq(cp, cy);
         cpsy_ff <= mulq(cp, sy);
         crsy_ff <= mulq(cr, sy);
         crcy_ff <= mulq(cr, cy);
         srsy_ff <= mulq(sr, sy);
         srcy_ff <= mulq(sr, cy);
         srcp_ff <= mulq(sr, cp);
         crcp_ff <= mulq(cr, cp);
         nsp_ff  <= -sp;
         cy_ff   <= cy;
         sy_ff   <= sy;
      end
   end

   // second products; other terms carried along
   trig_type pa_ff, pb_ff, pc_ff, pd_ff;
   trig_type cpcy2_ff, cpsy2_ff, crsy2_ff, crcy2_ff, srsy2_ff, srcy2_ff;
   trig_type srcp2_ff, crcp2_ff, nsp2_ff;

   always_ff @(posedge clock) begin
      if (en_s[S_M2]) begin
         pa_ff    <= mulq(srsp_ff, cy_ff);
         pb_ff    <= mulq(srsp_ff, sy_ff);
         pc_ff    <= mulq(crsp_ff, cy_ff);
         pd_ff    <= mulq(crsp_ff, sy_ff);
         cpcy2_ff <= cpcy_ff;
         cpsy2_ff <= cpsy_ff;
         crsy2_ff <= crsy_ff;
         crcy2_ff <= crcy_ff;
         srsy2_ff <= srsy_ff;
         srcy2_ff <= srcy_ff;
         srcp2_ff <= srcp_ff;
         crcp2_ff <= crcp_ff;
         nsp2_ff  <= nsp_ff;
      end
   end

   // matrix entries, row major
   trig_type m_ff [0:8];

   always_ff @(posedge clock) begin
      if (en_s[S_M3]) begin
         m_ff[0] <= cpcy2_ff;
         m_ff[1] <= pa_ff - crsy2_ff;
         m_ff[2] <= pc_ff + srsy2_ff;
         m_ff[3] <= cpsy2_ff;
         m_ff[4] <= pb_ff + crcy2_ff;
         m_ff[5] <= pd_ff - srcy2_ff;
         m_ff[6] <= nsp2_ff;
         m_ff[7] <= srcp2_ff;
         m_ff[8] <= crcp2_ff;
      end
   end

   // coordinate split into high and low halves times each entry
   logic signed [HW-1:0] hp_ff [0:8];
   logic signed [LW-1:0] lp_ff [0:8];

   always_ff @(posedge clock) begin
      if (en_s[S_R1]) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               hp_ff[3*r+k] <= HW'($signed(pt_ff[S_M3][k][COORD_WIDTH-1:16]) * m_ff[3*r+k]);
               lp_ff[3*r+k] <= LW'($signed({1'b0, pt_ff[S_M3][k][15:0]}) * m_ff[3*r+k]);
            end
         end
      end
   end

   // row sums
   logic signed [SAW-1:0] sa_ff [0:2];
   logic signed [SBW-1:0] sb_ff [0:2];

   always_ff @(posedge clock) begin
      if (en_s[S_R2]) begin
         for (int r = 0; r < 3; r++) begin
            sa_ff[r] <= SAW'(hp_ff[3*r]) + SAW'(hp_ff[3*r+1]) + SAW'(hp_ff[3*r+2]);
            sb_ff[r] <= SBW'(lp_ff[3*r]) + SBW'(lp_ff[3*r+1]) + SBW'(lp_ff[3*r+2]);
         end
      end
   end

   // round half up to Q16.16 and saturate
   logic signed [VW-1:0]          tot_in [0:2];
   logic signed [VW-15:0]         v_in   [0:2];
   logic signed [COORD_WIDTH-1:0] r_in   [0:2];
   logic signed [COORD_WIDTH-1:0] r_ff   [0:2];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         tot_in[r] = VW'(sa_ff[r]) + VW'(sb_ff[r] >>> 16) + VW'(14'sd4096 * 2);
         v_in[r]   = (VW-14)'(tot_in[r] >>> 14);
         if (v_in[r] > LimHi)      r_in[r] = COORD_WIDTH'(LimHi);
         else if (v_in[r] < LimLo) r_in[r] = COORD_WIDTH'(LimLo);
         else                      r_in[r] = COORD_WIDTH'(v_in[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (en_s[S_R3]) r_ff <= r_in;
   end

   assign rsp_ch.valid = v_ff[NS-1];
   assign rsp_ch.rx    = r_ff[0];
   assign rsp_ch.ry    = r_ff[1];
   assign rsp_ch.rz    = r_ff[2];

   // an empty front stage always takes an item
   a_front_open: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_ch.ready)
      else $error("front stage empty but request not ready");

   // a taking sink lets the whole pipeline advance
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("pipeline stalled although result is taken");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   // an unaccepted result stays valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("result dropped while stalled");
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for rotate_point_euler_3d: drives points and Euler angles, predicts each
// rotated point with an independent CORDIC and fixed-point model, and checks every item.
// Depends on rped_pkg, rped_if and the RTL of the rotator.
module tb;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] roll, pitch, yaw;
      logic               chk;  // typed-in result present
      logic signed [31:0] ex, ey, ez;
   } point_row_type;

   typedef struct {
      logic signed [31:0] x, y, z;
   } point_type;

   localparam logic signed [31:0] CMax = 32'sh7fffffff;
   localparam logic signed [31:0] CMin = 32'sh80000000;
   localparam logic signed [31:0] COne = 32'sh00010000;
   localparam logic signed [15:0] AHalfPi = 16'sh4000;
   localparam logic signed [15:0] APi = 16'sh8000;
   localparam int NumRandom = 2000;
   localparam int CycleLimit = 400000;

   logic clock;
   logic reset;
   int   cycles = 0;
   int   errors = 0;
   bit   no_gaps;

   rped_req_if #(.COORD_WIDTH(32), .ANGLE_WIDTH(16)) req_ch();
   rped_rsp_if #(.COORD_WIDTH(32)) rsp_ch();

   rotate_point_euler_3d i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   point_type rotated_q[$];

   // Arctangent table, 2^-32 turns
   function automatic longint atan_step(input int i);
      longint t[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
      return t[i];
   endfunction

   // Sine and cosine in Q2.30 after folding to the nearest quadrant
   function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                   output longint s);
      logic [31:0] a, u;
      logic [1:0]  q;
      longint      x, y, z, dx, dy;
      a = {ang, 16'h0};
      q = 2'((a + 32'h20000000) >> 30);
      u = a - ({30'h0, q} << 30);
      z = longint'($signed(u));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function automatic longint prod_q30(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // Exact dot product of the point with one matrix row, rounded and saturated
   function automatic logic signed [31:0] row_dot(input logic signed [31:0] x,
         input logic signed [31:0] y, input logic signed [31:0] z,
         input longint m0, input longint m1, input longint m2);
      logic signed [127:0] acc;
      acc = $signed(128'(x)) * m0 + $signed(128'(y)) * m1 + $signed(128'(z)) * m2;
      acc = (acc + (128'sd1 <<< 29)) >>> 30;
      if (acc > 128'sd2147483647) return CMax;
      if (acc < -128'sd2147483648) return CMin;
      return acc[31:0];
   endfunction

   function automatic point_type rotate_zyx(input point_row_type r);
      longint cr, sr, cp, sp, cy, sy, srsp, crsp;
      point_type o;
      sin_cos(r.roll, cr, sr);
      sin_cos(r.pitch, cp, sp);
      sin_cos(r.yaw, cy, sy);
      srsp = prod_q30(sr, sp);
      crsp = prod_q30(cr, sp);
      o.x = row_dot(r.px, r.py, r.pz, prod_q30(cp, cy),
                    prod_q30(srsp, cy) - prod_q30(cr, sy),
                    prod_q30(crsp, cy) + prod_q30(sr, sy));
      o.y = row_dot(r.px, r.py, r.pz, prod_q30(cp, sy),
                    prod_q30(srsp, sy) + prod_q30(cr, cy),
                    prod_q30(crsp, sy) - prod_q30(sr, cy));
      o.z = row_dot(r.px, r.py, r.pz, -sp, prod_q30(sr, cp), prod_q30(cr, cp));
      return o;
   endfunction

   // Clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Result check and random stall of the sink
   int stall_left;
   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rotated_q.size() == 0) begin
               $error("unexpected item rx=%0d ry=%0d rz=%0d", rsp_ch.rx, rsp_ch.ry, rsp_ch.rz);
               errors++;
            end else begin
               e = rotated_q.pop_front();
               if (rsp_ch.rx !== e.x) begin
                  $error("rx expected %0d actual %0d", e.x, rsp_ch.rx); errors++;
               end
               if (rsp_ch.ry !== e.y) begin
                  $error("ry expected %0d actual %0d", e.y, rsp_ch.ry); errors++;
               end
               if (rsp_ch.rz !== e.z) begin
                  $error("rz expected %0d actual %0d", e.z, rsp_ch.rz); errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_point(input point_row_type r);
      point_type e;
      if (!no_gaps && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.px <= r.px;
      req_ch.py <= r.py;
      req_ch.pz <= r.pz;
      req_ch.roll_angle <= r.roll;
      req_ch.pitch_angle <= r.pitch;
      req_ch.yaw_angle <= r.yaw;
      do @(posedge clock); while (!req_ch.ready);
      e = rotate_zyx(r);
      if (r.chk) begin
         e.x = r.ex; e.y = r.ey; e.z = r.ez;
      end
      rotated_q.push_back(e);
   endtask

   // Random angle, weighted towards multiples of an eighth turn and towards pi
   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 8) - 4);
         1: return APi;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0: return CMax;
         1: return CMin;
         2: return 32'($signed(16'($urandom)));
         3: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Directed rows: zero angles keep the point; quarter turns, half turns and extreme coordinates
   point_row_type directed[] = '{
      '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{COne, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{COne, COne, COne, AHalfPi, 0, 0, 0, 0, 0, 0},
      '{COne, COne, COne, 0, AHalfPi, 0, 0, 0, 0, 0},
      '{COne, COne, COne, 0, 0, AHalfPi, 0, 0, 0, 0},
      '{COne, 0, 0, APi, APi, APi, 0, 0, 0, 0},
      '{COne, -COne, COne, -AHalfPi, -AHalfPi, -AHalfPi, 0, 0, 0, 0},
      '{CMax, CMax, CMax, 16'sh2000, 16'sh2000, 16'sh2000, 0, 0, 0, 0},
      '{CMin, CMin, CMin, 16'sh2000, 16'sh2000, 16'sh2000, 0, 0, 0, 0},
      '{CMax, CMin, CMax, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0},
      '{CMin, CMax, 0, 16'sh1fff, 16'sh2001, 16'sh5fff, 0, 0, 0, 0},
      '{32'sh12345678, -32'sh0abcdef0, 32'sh00000001, 16'sh0001, -16'sh0001, 16'sh6000,
        0, 0, 0, 0},
      '{32'shffffffff, 1, 32'sh55555555, 16'sh5555, 16'shaaaa, 16'sh0000, 0, 0, 0, 0},
      '{CMax, 0, 0, 16'sh2000, 0, 16'sh2000, 0, 0, 0, 0}
   };

   // Stimulus and end of run
   initial begin
      point_row_type r;
      no_gaps = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.px = '0;
      req_ch.py = '0;
      req_ch.pz = '0;
      req_ch.roll_angle = '0;
      req_ch.pitch_angle = '0;
      req_ch.yaw_angle = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_point(directed[i]);
      // hold off until the pipeline has drained
      req_ch.valid <= 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
      for (int n = 0; n < NumRandom; n++) begin
         if (n == NumRandom - 300) no_gaps = 1'b1;
         r.px = rand_coord();
         r.py = rand_coord();
         r.pz = rand_coord();
         r.roll = rand_angle();
         r.pitch = rand_angle();
         r.yaw = rand_angle();
         r.chk = 1'b0;
         send_point(r);
      end
      req_ch.valid <= 1'b0;
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
